[design/tscb_pkg.sv]
// Shared types and constants of the text screen cursor buffer.
package tscb_pkg;

    // Default store geometry, handed to the top level parameters.
    localparam int DEF_MAX_ROWS = 32;
    localparam int DEF_MAX_COLS = 128;

    // Field widths of the stream words.
    localparam int CMD_W     = 4;
    localparam int ROW_IN_W  = 6;
    localparam int COL_IN_W  = 8;
    localparam int CHAR_W    = 8;
    localparam int POS_W     = 12;
    localparam int STATUS_W  = 2;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 24;

    // Configuration port.
    localparam int HEIGHT_W = 6;
    localparam int WIDTH_W  = 8;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 6'd24;
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 8'd80;

    // Characters with a meaning of their own.
    localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'd32;
    localparam logic [CHAR_W-1:0] NUL_CHAR   = 8'd0;

    // Register index, taken from paddr bit 2.
    typedef enum logic {
        REG_HEIGHT = 1'b0,
        REG_WIDTH  = 1'b1
    } t_reg;

    typedef enum logic [CMD_W-1:0] {
        CMD_HOME  = 4'd0,
        CMD_FWD   = 4'd1,
        CMD_BACK  = 4'd2,
        CMD_UP    = 4'd3,
        CMD_DOWN  = 4'd4,
        CMD_END   = 4'd5,
        CMD_MOVE  = 4'd6,
        CMD_WRITE = 4'd7,
        CMD_READ  = 4'd8,
        CMD_CLEAR = 4'd9
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_NULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_FILL,
        S_IDLE,
        S_READ
    } t_state;

    // What the cursor unit asks of the store for one command.
    typedef struct packed {
        logic    mem_wr;
        logic    mem_rd;
        logic    fill;
        t_status status;
    } t_step;

endpackage

[design/tscb_ram.sv]
// Generic single-port synchronous RAM with a registered read.
module tscb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read of the same address.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/tscb_cfg.sv]
// Configuration registers with their APB-style port and the clamped geometry.
module tscb_cfg #(
    parameter int MAX_ROWS = tscb_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = tscb_pkg::DEF_MAX_COLS,
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [tscb_pkg::PADDR_W-1:0]  i_paddr,
    input  logic [tscb_pkg::PDATA_W-1:0]  i_pwdata,
    output logic [tscb_pkg::PDATA_W-1:0]  o_prdata,
    output logic                          o_pready,
    output logic                          o_home,
    output logic [RW-1:0]                 o_hm1,
    output logic [CW-1:0]                 o_wm1
);
    import tscb_pkg::*;

    logic [HEIGHT_W-1:0] r_height;
    logic [WIDTH_W-1:0]  r_width;
    logic                wr_strobe;
    t_reg                reg_sel;

    assign o_pready  = 1'b1;
    assign wr_strobe = i_psel && i_penable && i_pwrite;
    assign reg_sel   = t_reg'(i_paddr[2]);
    // Any register write homes the cursor.
    assign o_home    = wr_strobe;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= HEIGHT_RESET;
            r_width  <= WIDTH_RESET;
        end else if (wr_strobe) begin
            unique case (reg_sel)
                REG_HEIGHT: r_height <= i_pwdata[HEIGHT_W-1:0];
                REG_WIDTH:  r_width  <= i_pwdata[WIDTH_W-1:0];
                default:    r_height <= r_height;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (reg_sel)
            REG_HEIGHT: o_prdata = PDATA_W'(r_height);
            REG_WIDTH:  o_prdata = PDATA_W'(r_width);
            default:    o_prdata = '0;
        endcase
    end

    // Geometry in use, minus one: zero counts as one, oversize as the maximum.
    always_comb begin
        if (r_height == '0) begin
            o_hm1 = '0;
        end else if (32'(r_height) > MAX_ROWS) begin
            o_hm1 = RW'(MAX_ROWS - 1);
        end else begin
            o_hm1 = RW'(r_height - HEIGHT_W'(1));
        end
        if (r_width == '0) begin
            o_wm1 = '0;
        end else if (32'(r_width) > MAX_COLS) begin
            o_wm1 = CW'(MAX_COLS - 1);
        end else begin
            o_wm1 = CW'(r_width - WIDTH_W'(1));
        end
    end

endmodule

[design/tscb_cursor.sv]
// Cursor row and column registers and the command decoder that moves them.
module tscb_cursor #(
    parameter int MAX_ROWS = tscb_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = tscb_pkg::DEF_MAX_COLS,
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int AW = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic                          i_home,
    input  logic [RW-1:0]                 i_hm1,
    input  logic [CW-1:0]                 i_wm1,
    input  tscb_pkg::t_cmd                i_cmd,
    input  logic [tscb_pkg::ROW_IN_W-1:0] i_row_in,
    input  logic [tscb_pkg::COL_IN_W-1:0] i_col_in,
    input  logic [tscb_pkg::CHAR_W-1:0]   i_char,
    output logic [AW-1:0]                 o_pos,
    output tscb_pkg::t_step               o_step
);
    import tscb_pkg::*;

    localparam int PW = RW + CW + 1;

    logic [RW-1:0] r_row, n_row, b_row;
    logic [CW-1:0] r_col, n_col, b_col;
    logic          target_ok;
    logic [CW:0]   w_eff;
    logic [PW-1:0] prod;

    // The cursor falls back to home when the screen has shrunk under it.
    always_comb begin
        if (r_row > i_hm1 || r_col > i_wm1) begin
            b_row = '0;
            b_col = '0;
        end else begin
            b_row = r_row;
            b_col = r_col;
        end
    end

    // A 1-based target lies on the screen in use.
    assign target_ok = (i_row_in != '0) && (32'(i_row_in) <= 32'(i_hm1) + 32'd1) &&
                       (i_col_in != '0) && (32'(i_col_in) <= 32'(i_wm1) + 32'd1);

    // Command decoder: next cursor and store access.
    always_comb begin
        n_row  = b_row;
        n_col  = b_col;
        o_step = '{mem_wr: 1'b0, mem_rd: 1'b0, fill: 1'b0, status: ST_OK};
        unique case (i_cmd) inside
            CMD_HOME: begin
                n_row = '0;
                n_col = '0;
            end
            CMD_FWD: begin
                if (b_col < i_wm1) begin
                    n_col = b_col + CW'(1);
                end else begin
                    n_col = '0;
                    n_row = (b_row < i_hm1) ? b_row + RW'(1) : '0;
                end
            end
            CMD_BACK: begin
                if (b_row == '0 && b_col == '0) begin
                    n_row = i_hm1;
                    n_col = i_wm1;
                end else if (b_col != '0) begin
                    n_col = b_col - CW'(1);
                end else begin
                    n_col = i_wm1;
                    n_row = b_row - RW'(1);
                end
            end
            CMD_UP: begin
                n_row = (b_row == '0) ? i_hm1 : b_row - RW'(1);
            end
            CMD_DOWN: begin
                n_row = (b_row >= i_hm1) ? '0 : b_row + RW'(1);
            end
            CMD_END: begin
                n_row = i_hm1;
                n_col = i_wm1;
            end
            CMD_MOVE, CMD_READ: begin
                o_step.mem_rd = (i_cmd == CMD_READ);
                if (target_ok) begin
                    n_row = RW'(i_row_in - ROW_IN_W'(1));
                    n_col = CW'(i_col_in - COL_IN_W'(1));
                end else begin
                    o_step.status = ST_RANGE;
                end
            end
            CMD_WRITE: begin
                if (i_char == NUL_CHAR) begin
                    o_step.status = ST_NULL;
                end else begin
                    o_step.mem_wr = 1'b1;
                end
            end
            CMD_CLEAR: begin
                o_step.fill = 1'b1;
                n_row       = '0;
                n_col       = '0;
            end
            default: begin
                n_row = b_row;
            end
        endcase
    end

    // Linear index of the new cursor: row times width plus column.
    assign w_eff = {1'b0, i_wm1} + (CW + 1)'(1);
    assign prod  = PW'(n_row) * PW'(w_eff);
    assign o_pos = AW'(prod + PW'(n_col));

    // Cursor registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_home) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

endmodule

[design/text_screen_cursor_buffer_top.sv]
// Top level of the text screen cursor buffer: handshakes, store sequencing and result register.
//
// Command words enter on the s_axis channel (cmd, target row and column, character) and one
// result word per command leaves on the m_axis channel (character read, cursor index, status).
// Screen height and width are set through the APB-style port; a register write homes the
// cursor but keeps the cells. The user is to write only while no command is in flight;
// the block itself does not enforce this. For cursor, write and move commands the result
// word is loaded at the edge that accepts the command; a new command may follow once that
// word is taken or is being taken. A read waits in S_READ for the registered read of the
// cell store, and its result is loaded in the cycle after acceptance.
// A clear returns its result at once and then sweeps all MAX_ROWS * MAX_COLS cells of the
// store (4096 by default), one cell a cycle; no command is taken during the sweep.
// After reset the same sweep fills every cell with the space character, so the block takes
// its first command once the sweep has ended.
// While the receiver stalls, the result word is held and the block takes no new command
// until that word has been taken or is being taken in the same cycle.
module text_screen_cursor_buffer_top #(
    parameter int MAX_ROWS = tscb_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = tscb_pkg::DEF_MAX_COLS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // cmd [3:0], target_row [9:4], target_col [17:10], char_in [25:18], zeros above
    input  logic [tscb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // char_out [7:0], cursor_pos [19:8], status [21:20], zeros above
    output logic [tscb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tscb_pkg::PADDR_W-1:0]     paddr,
    input  logic [tscb_pkg::PDATA_W-1:0]     pwdata,
    output logic [tscb_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);
    import tscb_pkg::*;

    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] FILL_LAST = AW'(DEPTH - 1);

    t_state              r_state, n_state;
    logic                r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]   r_out_char, n_out_char;
    logic [AW-1:0]       r_out_pos, n_out_pos;
    t_status             r_out_status, n_out_status;
    logic [AW-1:0]       r_pend_pos, n_pend_pos;
    t_status             r_pend_status, n_pend_status;
    logic [AW-1:0]       r_fill_addr, n_fill_addr;
    logic [CHAR_W-1:0]   r_fill_char, n_fill_char;

    logic                accept;
    logic                cfg_home;
    logic [RW-1:0]       hm1;
    logic [CW-1:0]       wm1;
    t_cmd                in_cmd;
    logic [ROW_IN_W-1:0] in_row;
    logic [COL_IN_W-1:0] in_col;
    logic [CHAR_W-1:0]   in_char;
    logic [AW-1:0]       cur_pos;
    t_step               step;
    logic                ram_we;
    logic [AW-1:0]       ram_addr;
    logic [CHAR_W-1:0]   ram_wdata;
    logic [CHAR_W-1:0]   ram_rdata;

    // Unpack the command word.
    assign in_cmd  = t_cmd'(s_axis_tdata[3:0]);
    assign in_row  = s_axis_tdata[9:4];
    assign in_col  = s_axis_tdata[17:10];
    assign in_char = s_axis_tdata[25:18];

    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    tscb_cfg #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_home    (cfg_home),
        .o_hm1     (hm1),
        .o_wm1     (wm1)
    );

    tscb_cursor #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_cursor (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_home   (cfg_home),
        .i_hm1    (hm1),
        .i_wm1    (wm1),
        .i_cmd    (in_cmd),
        .i_row_in (in_row),
        .i_col_in (in_col),
        .i_char   (in_char),
        .o_pos    (cur_pos),
        .o_step   (step)
    );

    // Store port: the sweep owns it while filling, otherwise the cursor index.
    assign ram_we    = (r_state == S_FILL) || (accept && step.mem_wr);
    assign ram_addr  = (r_state == S_FILL) ? r_fill_addr : cur_pos;
    assign ram_wdata = (r_state == S_FILL) ? r_fill_char : in_char;

    tscb_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Sequencer: next state, result register and fill sweep.
    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid;
        n_out_char    = r_out_char;
        n_out_pos     = r_out_pos;
        n_out_status  = r_out_status;
        n_pend_pos    = r_pend_pos;
        n_pend_status = r_pend_status;
        n_fill_addr   = r_fill_addr;
        n_fill_char   = r_fill_char;
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_FILL: begin
                if (r_fill_addr == FILL_LAST) begin
                    n_fill_addr = '0;
                    n_state     = S_IDLE;
                end else begin
                    n_fill_addr = r_fill_addr + AW'(1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (step.mem_rd) begin
                        n_pend_pos    = cur_pos;
                        n_pend_status = step.status;
                        n_state       = S_READ;
                    end else begin
                        n_out_valid  = 1'b1;
                        n_out_char   = NUL_CHAR;
                        n_out_pos    = cur_pos;
                        n_out_status = step.status;
                    end
                    if (step.fill) begin
                        n_fill_char = in_char;
                        n_fill_addr = '0;
                        n_state     = S_FILL;
                    end
                end
            end
            S_READ: begin
                n_out_valid  = 1'b1;
                n_out_char   = ram_rdata;
                n_out_pos    = r_pend_pos;
                n_out_status = r_pend_status;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_out_valid <= 1'b0;
            r_fill_addr <= '0;
            r_fill_char <= SPACE_CHAR;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_fill_addr <= n_fill_addr;
            r_fill_char <= n_fill_char;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_out_char    <= n_out_char;
        r_out_pos     <= n_out_pos;
        r_out_status  <= n_out_status;
        r_pend_pos    <= n_pend_pos;
        r_pend_status <= n_pend_status;
    end

    // Pack the result word.
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_status, POS_W'(r_out_pos), r_out_char};

    // A read leaves its wait state in the cycle after it enters it.
    a_read_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_state == S_IDLE))
        else $error("read wait lasted more than one cycle");

    // The result register is free when read data arrives.
    a_read_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !r_out_valid)
        else $error("read result would overwrite a pending word");

    // No command is taken while the store is swept.
    a_no_accept_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> !s_axis_tready)
        else $error("command accepted during fill sweep");

    // The sweep ends after the last cell.
    a_fill_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL && r_fill_addr == FILL_LAST) |=> (r_state == S_IDLE))
        else $error("fill sweep did not end at the last cell");

endmodule

[tb/sv/text_screen_cursor_buffer_top_test.sv]
// Self-checking testbench for the text screen cursor buffer, with its own model of the screen.
`timescale 1ns / 100ps

module text_screen_cursor_buffer_top_test;

    import tscb_pkg::*;

    localparam int STORE_CELLS  = DEF_MAX_ROWS * DEF_MAX_COLS;
    localparam int SETTLE_WAIT  = STORE_CELLS + 16;
    localparam int LONG_HOLD    = 300;
    localparam int SHOWN_ERRORS = 10;
    localparam int PHASE_ITEMS  = 45;

    // One result word as the block should return it.
    typedef struct packed {
        logic [CHAR_W-1:0]   ch;
        logic [POS_W-1:0]    pos;
        logic [STATUS_W-1:0] status;
    } t_screen_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_W-1:0]     paddr = '0;
    logic [PDATA_W-1:0]     pwdata = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    text_screen_cursor_buffer_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // Model of the screen: registers, cursor and cell store.
    logic [HEIGHT_W-1:0] rows_reg = HEIGHT_RESET;
    logic [WIDTH_W-1:0]  cols_reg = WIDTH_RESET;
    int                  cur_row = 0;
    int                  cur_col = 0;
    logic [CHAR_W-1:0]   cells [STORE_CELLS];

    t_screen_result due_results [$];

    int err_count = 0;
    int words_sent = 0;
    int words_checked = 0;
    int clears_sent = 0;
    int reads_sent = 0;
    int geometries = 1;

    // Sender burst state and the flag that asks the receiver for a long hold.
    int burst_left = 0;
    bit offer_up = 1'b0;
    bit long_hold_wanted = 1'b0;

    initial begin
        foreach (cells[i]) cells[i] = SPACE_CHAR;
    end

    function automatic int rows_in_use();
        if (rows_reg == 0) return 1;
        if (rows_reg > DEF_MAX_ROWS) return DEF_MAX_ROWS;
        return int'(rows_reg);
    endfunction

    function automatic int cols_in_use();
        if (cols_reg == 0) return 1;
        if (cols_reg > DEF_MAX_COLS) return DEF_MAX_COLS;
        return int'(cols_reg);
    endfunction

    // Applies one command word to the model and returns the result it should give.
    function automatic t_screen_result predict_cursor_result(logic [IN_TDATA_W-1:0] word);
        logic [CMD_W-1:0] cmd;
        int tr;
        int tc;
        logic [CHAR_W-1:0] ch;
        int h;
        int w;
        int idx;
        t_screen_result r;
        cmd = word[3:0];
        tr  = int'(word[9:4]);
        tc  = int'(word[17:10]);
        ch  = word[25:18];
        h   = rows_in_use();
        w   = cols_in_use();
        r   = '0;
        r.status = ST_OK;
        if (cur_row >= h || cur_col >= w) begin
            cur_row = 0;
            cur_col = 0;
        end
        case (cmd) inside
            CMD_HOME: begin
                cur_row = 0;
                cur_col = 0;
            end
            CMD_FWD: begin
                if (cur_col + 1 < w) begin
                    cur_col++;
                end else begin
                    cur_col = 0;
                    cur_row = (cur_row + 1 < h) ? cur_row + 1 : 0;
                end
            end
            CMD_BACK: begin
                if (cur_row == 0 && cur_col == 0) begin
                    cur_row = h - 1;
                    cur_col = w - 1;
                end else if (cur_col > 0) begin
                    cur_col--;
                end else begin
                    cur_col = w - 1;
                    cur_row--;
                end
            end
            CMD_UP: cur_row = (cur_row == 0) ? h - 1 : cur_row - 1;
            CMD_DOWN: cur_row = (cur_row + 1 >= h) ? 0 : cur_row + 1;
            CMD_END: begin
                cur_row = h - 1;
                cur_col = w - 1;
            end
            CMD_MOVE, CMD_READ: begin
                if (tr >= 1 && tr <= h && tc >= 1 && tc <= w) begin
                    cur_row = tr - 1;
                    cur_col = tc - 1;
                end else begin
                    r.status = ST_RANGE;
                end
            end
            CMD_WRITE: begin
                if (ch == NUL_CHAR) r.status = ST_NULL;
            end
            CMD_CLEAR: begin
                foreach (cells[i]) cells[i] = ch;
                cur_row = 0;
                cur_col = 0;
            end
            default: ;
        endcase
        idx = cur_row * w + cur_col;
        if (idx >= STORE_CELLS) idx = 0;
        if (cmd == CMD_WRITE && ch != NUL_CHAR) cells[idx] = ch;
        if (cmd == CMD_READ) r.ch = cells[idx];
        r.pos = idx[POS_W-1:0];
        return r;
    endfunction

    function automatic logic [IN_TDATA_W-1:0] cmd_word(logic [CMD_W-1:0] op, int row, int col,
                                                       int ch);
        logic [ROW_IN_W-1:0] r;
        logic [COL_IN_W-1:0] c;
        logic [CHAR_W-1:0]   x;
        r = row[ROW_IN_W-1:0];
        c = col[COL_IN_W-1:0];
        x = ch[CHAR_W-1:0];
        return {6'b0, x, c, r, op};
    endfunction

    // Mostly well-formed commands on the screen in use, with some out-of-range noise.
    // The plain cursor commands, home up to end, share one band of picks.
    function automatic logic [IN_TDATA_W-1:0] random_command();
        logic [CMD_W-1:0] op;
        int pick;
        int row;
        int col;
        int ch;
        pick = $urandom_range(0, 99);
        if (pick < 20)      op = CMD_WRITE;
        else if (pick < 40) op = CMD_READ;
        else if (pick < 52) op = CMD_MOVE;
        else if (pick < 95) op = CMD_W'($urandom_range(int'(CMD_HOME), int'(CMD_END)));
        else if (pick < 98) op = CMD_W'($urandom_range(10, 15));
        else                op = CMD_CLEAR;
        row = ($urandom_range(0, 4) != 0) ? $urandom_range(1, rows_in_use())
                                          : $urandom_range(0, 63);
        col = ($urandom_range(0, 4) != 0) ? $urandom_range(1, cols_in_use())
                                          : $urandom_range(0, 255);
        ch  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 255);
        return cmd_word(op, row, col, ch);
    endfunction

    task automatic note_mismatch(input string what, input longint expv, input longint actv);
        err_count++;
        if (err_count <= SHOWN_ERRORS)
            $display("[%0t] mismatch in %s: expected %0d, got %0d", $realtime, what, expv, actv);
    endtask

    // Offers one command word, records its expected result once it is taken, then
    // keeps or ends the current burst.
    task automatic send_command(input logic [IN_TDATA_W-1:0] word);
        int gap;
        s_axis_tdata  <= word;
        s_axis_tvalid <= 1'b1;
        offer_up = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        due_results.push_back(predict_cursor_result(word));
        words_sent++;
        if (word[3:0] == CMD_CLEAR) clears_sent++;
        if (word[3:0] == CMD_READ) reads_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                offer_up = 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic end_burst();
        if (offer_up) begin
            s_axis_tvalid <= 1'b0;
            offer_up = 1'b0;
        end
    endtask

    // Waits until every result is in and any clear sweep has run out.
    task automatic settle();
        end_burst();
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    // A setup phase and an access phase on the register port, then the port is idled.
    task automatic apb_access(input logic wr, input t_reg sel, input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {sel, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_screen_reg(input t_reg sel);
        logic [PDATA_W-1:0] got;
        logic [PDATA_W-1:0] want;
        apb_access(1'b0, sel, '0, got);
        want = (sel == REG_HEIGHT) ? PDATA_W'(rows_reg) : PDATA_W'(cols_reg);
        if (got !== want) note_mismatch(sel.name(), want, got);
    endtask

    // Writes both geometry registers, with noise in the unused upper bits, and reads them back.
    task automatic set_geometry(input int height, input int width);
        logic [PDATA_W-1:0] unused;
        logic [PDATA_W-1:0] noise;
        noise = $urandom() & ~32'h3F;
        apb_access(1'b1, REG_HEIGHT, noise | height, unused);
        rows_reg = height[HEIGHT_W-1:0];
        cur_row = 0;
        cur_col = 0;
        noise = $urandom() & ~32'hFF;
        apb_access(1'b1, REG_WIDTH, noise | width, unused);
        cols_reg = width[WIDTH_W-1:0];
        cur_row = 0;
        cur_col = 0;
        check_screen_reg(REG_HEIGHT);
        check_screen_reg(REG_WIDTH);
        geometries++;
    endtask

    // Reset values of the registers and of the cells.
    task automatic test_reset_state();
        check_screen_reg(REG_HEIGHT);
        check_screen_reg(REG_WIDTH);
        send_command(cmd_word(CMD_READ, 1, 1, 0));
    endtask

    // Every cursor command, including the wraps at both ends of the screen.
    task automatic test_cursor_wraps();
        send_command(cmd_word(CMD_HOME, 0, 0, 0));
        send_command(cmd_word(CMD_BACK, 0, 0, 0));
        send_command(cmd_word(CMD_FWD, 0, 0, 0));
        send_command(cmd_word(CMD_UP, 0, 0, 0));
        send_command(cmd_word(CMD_DOWN, 0, 0, 0));
        send_command(cmd_word(CMD_END, 0, 0, 0));
        send_command(cmd_word(CMD_MOVE, 2, 1, 0));
        send_command(cmd_word(CMD_BACK, 0, 0, 0));
    endtask

    // Moves and reads outside the screen leave the cursor in place and flag a range status.
    task automatic test_range_errors();
        send_command(cmd_word(CMD_MOVE, 0, 5, 0));
        send_command(cmd_word(CMD_MOVE, 25, 5, 0));
        send_command(cmd_word(CMD_MOVE, 5, 0, 0));
        send_command(cmd_word(CMD_MOVE, 5, 81, 0));
        send_command(cmd_word(CMD_READ, 63, 255, 0));
    endtask

    // A write in the last cell, an ignored null write, and a read back.
    task automatic test_write_and_null();
        send_command(cmd_word(CMD_MOVE, 24, 80, 0));
        send_command(cmd_word(CMD_WRITE, 0, 0, 255));
        send_command(cmd_word(CMD_WRITE, 0, 0, 0));
        send_command(cmd_word(CMD_READ, 24, 80, 0));
    endtask

    // Clear with the null character, a read of the fill, then clear back to spaces.
    task automatic test_clear_fill();
        send_command(cmd_word(CMD_CLEAR, 0, 0, 0));
        send_command(cmd_word(CMD_READ, 3, 3, 0));
        send_command(cmd_word(CMD_CLEAR, 63, 255, 32));
    endtask

    // Codes above clear change nothing.
    task automatic test_unused_codes();
        send_command(cmd_word(CMD_W'(10), 63, 255, 255));
        send_command(cmd_word(CMD_W'(15), 1, 1, 1));
    endtask

    // Random commands over a range of screen shapes, the register extremes among them.
    task automatic test_random_geometries();
        int heights [8] = '{0, 63, 1, 32, 3, 4, 2, 24};
        int widths  [8] = '{0, 255, 128, 1, 5, 4, 7, 80};
        foreach (heights[p]) begin
            settle();
            set_geometry(heights[p], widths[p]);
            repeat (PHASE_ITEMS) send_command(random_command());
        end
    endtask

    // The receiver holds off for a long stretch while commands keep coming.
    task automatic test_output_backpressure();
        settle();
        set_geometry(3, 6);
        long_hold_wanted = 1'b1;
        repeat (25) send_command(random_command());
    endtask

    // Receiver: ready on a pattern of changing duty, or a long hold when asked.
    initial begin
        int mode;
        int mode_left;
        mode = 0;
        mode_left = 0;
        forever begin
            if (long_hold_wanted) begin
                long_hold_wanted = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    default: m_axis_tready <= ($urandom_range(0, 4) == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    // Each result word taken is compared with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_screen_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (due_results.size() == 0) begin
                note_mismatch("result word with nothing expected", 0, m_axis_tdata);
            end else begin
                want = due_results.pop_front();
                words_checked++;
                if (m_axis_tdata[7:0] !== want.ch)
                    note_mismatch("char_out", want.ch, m_axis_tdata[7:0]);
                if (m_axis_tdata[19:8] !== want.pos)
                    note_mismatch("cursor_pos", want.pos, m_axis_tdata[19:8]);
                if (m_axis_tdata[21:20] !== want.status)
                    note_mismatch("status", want.status, m_axis_tdata[21:20]);
            end
        end
    end

    // Watchdog.
    initial begin
        #10_000_000;
        $display("Run stopped by the watchdog with %0d results outstanding.", due_results.size());
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int waited;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_cursor_wraps();
        test_range_errors();
        test_write_and_null();
        test_clear_fill();
        test_unused_codes();
        test_random_geometries();
        test_output_backpressure();

        // Drain, then watch a little longer for stray words.
        end_burst();
        waited = 0;
        while (due_results.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);
        if (due_results.size() != 0) begin
            err_count += due_results.size();
            $display("%0d expected results never arrived.", due_results.size());
        end

        $display("Sent %0d command words over %0d screen shapes (%0d clears, %0d reads).",
                 words_sent, geometries, clears_sent, reads_sent);
        $display("Checked %0d result words; %0d mismatches.", words_checked, err_count);
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
design/tscb_pkg.sv
design/tscb_ram.sv
design/tscb_cfg.sv
design/tscb_cursor.sv
design/text_screen_cursor_buffer_top.sv
tb/sv/text_screen_cursor_buffer_top_test.sv
